>>> rtl/core/accel_tilt_angle_core_defines.svh
// Assertion macros shared by the tilt angle core.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef ACCEL_TILT_ANGLE_CORE_DEFINES_SVH
`define ACCEL_TILT_ANGLE_CORE_DEFINES_SVH

// Same-cycle implication, muted while in reset.
`define ATA_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while in reset.
`define ATA_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ata_pkg.sv
// Constants, types and the arctangent table for the tilt angle core.
// No dependencies; imported by every module of the core.
package ata_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int CORDIC_STAGES   = 16;
    localparam int WORK_FRAC       = 24;
    localparam int TABLE_LEN       = 24;

    localparam int PRE_SHIFT = (63 - 2 * SAMPLE_BITS) / 2;
    localparam int SUM_W     = 2 * SAMPLE_BITS;
    localparam int ROOT_W    = SAMPLE_BITS + PRE_SHIFT;
    localparam int REM_W     = ROOT_W + 2;
    localparam int CD_W      = ROOT_W + 3;
    localparam int Z_W       = WORK_FRAC + 9;
    localparam int STAGE_W   = $clog2(TABLE_LEN);
    localparam int ANGLE_W   = 16;
    localparam int RND_SH    = WORK_FRAC - ANGLE_FRAC_BITS;
    localparam int RES_W     = Z_W - RND_SH;

    // atan(2^-i) in degrees, 24 fractional bits
    localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

    localparam logic [Z_W-1:0]            Z_MAX     = Z_W'({ATAN_TAB[0], 1'b0});
    localparam logic [RES_W-1:0]          FULL_MAG  = RES_W'(90 << ANGLE_FRAC_BITS);
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(90 << ANGLE_FRAC_BITS);

    typedef struct packed {
        logic valid;
        logic neg;
        logic zero_n;
        logic zero_d;
    } t_tag;

    typedef struct packed {
        logic [REM_W-1:0]       rem;
        logic [ROOT_W-1:0]      root;
        logic [SUM_W-1:0]       src;
        logic [SAMPLE_BITS-1:0] nmag;
    } t_sqrt;

    typedef struct packed {
        logic signed [CD_W-1:0] x;
        logic signed [CD_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

    function automatic logic [31:0] atan_lookup(input logic [STAGE_W-1:0] idx);
        logic [31:0] v;
        v = '0;
        if (idx < STAGE_W'(TABLE_LEN)) begin
            v = ATAN_TAB[idx];
        end
        return v;
    endfunction

endpackage

>>> rtl/core/accel_tilt_angle_core.sv
// Tilt angle core: roll or pitch from one accelerometer sample per transfer.
// Pipeline: 3 front stages, 31 square root cells, 16 CORDIC cells and an
// output register.
// Throughput: one transfer per cycle; the whole chain holds while the output is stalled.
// Reset: synchronous, active low; clears all valid flags, input stalled during reset.
// Depends on ata_pkg, ata_sqrt_cell, ata_cordic_cell and the defines header.
`include "accel_tilt_angle_core_defines.svh"

module accel_tilt_angle_core
    import ata_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [ANGLE_W-1:0]     o_tilt_angle
);

    logic w_adv;

    logic signed [SAMPLE_BITS-1:0] w_n;
    logic signed [SAMPLE_BITS-1:0] w_a;
    t_tag                          n_s0_tag;

    t_tag                   r_s0_tag;
    logic [SAMPLE_BITS-1:0] r_s0_nmag;
    logic [SAMPLE_BITS-1:0] r_s0_ma;
    logic [SAMPLE_BITS-1:0] r_s0_mb;

    t_tag                   r_s1_tag;
    logic [SAMPLE_BITS-1:0] r_s1_nmag;
    logic [SUM_W-1:0]       r_s1_pa;
    logic [SUM_W-1:0]       r_s1_pb;

    logic [SUM_W-1:0] w_sum;
    t_tag             n_s2_tag;
    t_sqrt            n_s2_data;
    t_tag             r_s2_tag;
    t_sqrt            r_s2_data;

    t_tag    sq_tag  [ROOT_W+1];
    t_sqrt   sq_data [ROOT_W+1];
    t_tag    cd_tag  [CORDIC_STAGES+1];
    t_cordic cd_data [CORDIC_STAGES+1];

    logic signed [Z_W-1:0]   w_z;
    logic [Z_W-1:0]          w_zc;
    logic [Z_W-1:0]          w_rsum;
    logic [RES_W-1:0]        w_mag;
    logic [ANGLE_W-1:0]      w_res;
    logic [ANGLE_W-1:0]      n_out;
    logic                    r_out_valid;
    logic [ANGLE_W-1:0]      r_out;

    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = !i_rst_n || !w_adv;

    // front: operand selection, magnitudes, squares and their sum
    always_comb begin
        w_n = i_command ? i_accel_x : i_accel_y;
        w_a = i_command ? i_accel_y : i_accel_x;
        n_s0_tag.valid  = i_valid;
        n_s0_tag.neg    = w_n[SAMPLE_BITS-1];
        n_s0_tag.zero_n = (w_n == '0);
        n_s0_tag.zero_d = 1'b0;
    end

    always_comb begin
        w_sum = r_s1_pa + r_s1_pb;
        n_s2_tag        = r_s1_tag;
        n_s2_tag.zero_d = (w_sum == '0);
        n_s2_data.rem   = '0;
        n_s2_data.root  = '0;
        n_s2_data.src   = w_sum;
        n_s2_data.nmag  = r_s1_nmag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_tag <= '0;
            r_s1_tag <= '0;
            r_s2_tag <= '0;
        end else if (w_adv) begin
            r_s0_tag <= n_s0_tag;
            r_s1_tag <= r_s0_tag;
            r_s2_tag <= n_s2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_nmag <= w_n[SAMPLE_BITS-1] ? SAMPLE_BITS'(-w_n) : SAMPLE_BITS'(w_n);
            r_s0_ma   <= w_a[SAMPLE_BITS-1] ? SAMPLE_BITS'(-w_a) : SAMPLE_BITS'(w_a);
            r_s0_mb   <= i_accel_z[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_accel_z)
                                                  : SAMPLE_BITS'(i_accel_z);
            r_s1_nmag <= r_s0_nmag;
            r_s1_pa   <= r_s0_ma * r_s0_ma;
            r_s1_pb   <= r_s0_mb * r_s0_mb;
            r_s2_data <= n_s2_data;
        end
    end

    // square root chain
    assign sq_tag[0]  = r_s2_tag;
    assign sq_data[0] = r_s2_data;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        ata_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tag   (sq_tag[g]),
            .i_data  (sq_data[g]),
            .o_tag   (sq_tag[g+1]),
            .o_data  (sq_data[g+1])
        );
    end

    // CORDIC chain
    assign cd_tag[0]    = sq_tag[ROOT_W];
    assign cd_data[0].x = $signed({{(CD_W-ROOT_W){1'b0}}, sq_data[ROOT_W].root});
    assign cd_data[0].y = $signed(CD_W'({sq_data[ROOT_W].nmag, {PRE_SHIFT{1'b0}}}));
    assign cd_data[0].z = '0;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        ata_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_stage (STAGE_W'(g)),
            .i_tag   (cd_tag[g]),
            .i_data  (cd_data[g]),
            .o_tag   (cd_tag[g+1]),
            .o_data  (cd_data[g+1])
        );
    end

    // clamp, round half up, zero operand cases, sign
    always_comb begin
        w_z = cd_data[CORDIC_STAGES].z;
        if (w_z[Z_W-1]) begin
            w_zc = '0;
        end else if (w_z > $signed(Z_MAX)) begin
            w_zc = Z_MAX;
        end else begin
            w_zc = w_z;
        end
        w_rsum = w_zc + (Z_W'(1) << (RND_SH - 1));
        w_mag  = w_rsum[Z_W-1:RND_SH];
        if (w_mag > FULL_MAG) begin
            w_mag = FULL_MAG;
        end
        if (cd_tag[CORDIC_STAGES].zero_n) begin
            w_res = '0;
        end else if (cd_tag[CORDIC_STAGES].zero_d) begin
            w_res = ANGLE_W'(FULL_MAG);
        end else begin
            w_res = ANGLE_W'(w_mag);
        end
        n_out = cd_tag[CORDIC_STAGES].neg ? ANGLE_W'(-w_res) : w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= cd_tag[CORDIC_STAGES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_tilt_angle = $signed(r_out);

    `ATA_IMPLIES(a_out_range, o_valid, (o_tilt_angle <= ANGLE_MAX) && (o_tilt_angle >= -ANGLE_MAX), "tilt angle beyond ninety degrees")
    `ATA_IMPLIES(a_stall_cause, o_stall, o_valid && i_stall, "input stalled without a held result")
    `ATA_NEXT(a_accept_enters, i_valid && !o_stall, r_s0_tag.valid, "accepted transfer lost at entry")
    `ATA_NEXT(a_hold_on_stall, o_stall, $stable(r_s0_tag), "entry stage moved while stalled")
    `ATA_IMPLIES(a_zero_root, cd_tag[0].valid, cd_tag[0].zero_d == (sq_data[ROOT_W].root == '0), "zero denominator flag disagrees with root")

endmodule

>>> rtl/core/ata_sqrt_cell.sv
// One digit of the pipelined integer square root: two radicand bits in, one root bit out.
// Depends on ata_pkg.
module ata_sqrt_cell
    import ata_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  t_tag  i_tag,
    input  t_sqrt i_data,
    output t_tag  o_tag,
    output t_sqrt o_data
);

    t_tag              r_tag;
    t_sqrt             r_data;
    t_sqrt             n_data;
    logic [REM_W+1:0]  w_acc;
    logic [REM_W+1:0]  w_trial;
    logic              w_fit;

    always_comb begin
        w_acc   = {i_data.rem, i_data.src[SUM_W-1 -: 2]};
        w_trial = {2'b00, i_data.root, 2'b01};
        w_fit   = (w_acc >= w_trial);
        n_data.rem  = w_fit ? REM_W'(w_acc - w_trial) : REM_W'(w_acc);
        n_data.root = {i_data.root[ROOT_W-2:0], w_fit};
        n_data.src  = {i_data.src[SUM_W-3:0], 2'b00};
        n_data.nmag = i_data.nmag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_adv) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_tag  = r_tag;
    assign o_data = r_data;

endmodule

>>> rtl/core/ata_cordic_cell.sv
// One vectoring rotation of the CORDIC arctangent chain.
// Depends on ata_pkg for widths and the angle table.
module ata_cordic_cell
    import ata_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic [STAGE_W-1:0] i_stage,
    input  t_tag               i_tag,
    input  t_cordic            i_data,
    output t_tag               o_tag,
    output t_cordic            o_data
);

    t_tag                   r_tag;
    t_cordic                r_data;
    t_cordic                n_data;
    logic signed [CD_W-1:0] w_xs;
    logic signed [CD_W-1:0] w_ys;
    logic signed [Z_W-1:0]  w_ang;

    always_comb begin
        w_xs  = i_data.x >>> i_stage;
        w_ys  = i_data.y >>> i_stage;
        w_ang = $signed(Z_W'(atan_lookup(i_stage)));
        if (!i_data.y[CD_W-1]) begin
            n_data.x = i_data.x + w_ys;
            n_data.y = i_data.y - w_xs;
            n_data.z = i_data.z + w_ang;
        end else begin
            n_data.x = i_data.x - w_ys;
            n_data.y = i_data.y + w_xs;
            n_data.z = i_data.z - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_adv) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_tag  = r_tag;
    assign o_data = r_data;

endmodule
